// ===== sv/mstb_pkg.sv =====
`timescale 1ns / 1ps

package mstb_pkg;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_ACK    = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BUSY        = 2'd1;
  localparam logic [1:0] ST_NOT_RUNNING = 2'd2;
  localparam logic [1:0] ST_PENDING     = 2'd3;

  localparam int MASK_W = 8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  timer_id;
    logic [31:0] length_ticks;
    logic        periodic;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [MASK_W-1:0] expired_mask;
    logic [MASK_W-1:0] finished_mask;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/mstb_ctrl.sv =====
`timescale 1ns / 1ps

module mstb_ctrl
  import mstb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] mode,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_ACK_RD,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_valid && in_ready;
    cmd.exec     = (state == S_EXEC);
    cmd.load_out = (state == S_FINISH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (mode)
              MODE_TICK:  state <= S_SWEEP;
              MODE_ACK:   state <= S_ACK_RD;
              default:    state <= S_EXEC;
            endcase
          end
        end
        S_SWEEP: begin
          if (stat.sweep_done) begin
            state <= S_FINISH;
          end
        end
        S_ACK_RD: state <= S_EXEC;
        S_EXEC:   state <= S_FINISH;
        S_FINISH: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mstb_dpath.sv =====
`timescale 1ns / 1ps

module mstb_dpath
  import mstb_pkg::*;
#(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DW = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;
  localparam logic [IW-1:0] LAST = IW'(NUM_TIMERS - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACTIVE,
    PH_DONE
  } phase_t;

  // per-slot control in flops, counts in memories
  phase_t                 phase [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  rep;
  logic [COUNT_WIDTH-1:0] ticks_mem  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_mem [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] ticks_rdata;
  logic [COUNT_WIDTH-1:0] reload_rdata;

  // captured item
  logic [1:0]             mode_q;
  logic [2:0]             id_q;
  logic [COUNT_WIDTH-1:0] len_q;
  logic                   per_q;
  logic [1:0]             status_q;
  logic [DW-1:0]          expired;

  // sweep pipeline: issue read, then update
  logic                   issue_on;
  logic [IW-1:0]          issue_idx;
  logic                   p_valid;
  logic [IW-1:0]          p_idx;

  logic                   id_ok;
  logic [IW-1:0]          slot;
  logic                   ticks_we;
  logic [IW-1:0]          ticks_wa;
  logic [COUNT_WIDTH-1:0] ticks_wd;
  logic                   reload_we;
  logic                   sweep_hit;
  logic                   sweep_expire;
  logic [DW-1:0]          done_vec;

  assign id_ok = (32'(id_q) < NUM_TIMERS);
  assign slot  = IW'(id_q);

  assign sweep_hit    = p_valid && (phase[p_idx] == PH_ACTIVE);
  assign sweep_expire = sweep_hit && (ticks_rdata <= COUNT_WIDTH'(1));

  assign stat.sweep_done = p_valid && (p_idx == LAST);
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    done_vec = '0;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      done_vec[s] = (phase[s] == PH_DONE);
    end
  end

  // single write port of the countdown memory
  always_comb begin
    ticks_we  = 1'b0;
    ticks_wa  = slot;
    ticks_wd  = len_q;
    reload_we = 1'b0;
    if (sweep_hit && !sweep_expire) begin
      ticks_we = 1'b1;
      ticks_wa = p_idx;
      ticks_wd = ticks_rdata - COUNT_WIDTH'(1);
    end else if (cmd.exec && id_ok) begin
      case (mode_q)
        MODE_START: begin
          ticks_we  = (phase[slot] == PH_IDLE);
          reload_we = (phase[slot] == PH_IDLE);
        end
        MODE_ACK: begin
          ticks_we = (phase[slot] == PH_DONE) && rep[slot];
          ticks_wd = reload_rdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ticks_we) begin
      ticks_mem[ticks_wa] <= ticks_wd;
    end
    if (reload_we) begin
      reload_mem[slot] <= len_q;
    end
    ticks_rdata  <= ticks_mem[issue_idx];
    reload_rdata <= reload_mem[slot];
  end

  // item capture and sweep sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on  <= 1'b0;
      issue_idx <= '0;
      p_valid   <= 1'b0;
      p_idx     <= '0;
    end else begin
      p_valid <= issue_on;
      p_idx   <= issue_idx;
      if (cmd.capture) begin
        issue_on  <= (in_data.mode == MODE_TICK);
        issue_idx <= '0;
      end else if (issue_on) begin
        if (issue_idx == LAST) begin
          issue_on <= 1'b0;
        end else begin
          issue_idx <= issue_idx + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= in_data.mode;
      id_q     <= in_data.timer_id;
      len_q    <= COUNT_WIDTH'(in_data.length_ticks);
      per_q    <= in_data.periodic;
      status_q <= ST_OK;
      expired  <= '0;
    end else begin
      if (sweep_expire) begin
        expired <= expired | (DW'(1) << p_idx);
      end
      if (cmd.exec) begin
        case (mode_q)
          MODE_START: begin
            if (!id_ok || phase[slot] != PH_IDLE) begin
              status_q <= ST_BUSY;
            end
          end
          MODE_ACK: begin
            if (!id_ok || phase[slot] == PH_IDLE) begin
              status_q <= ST_NOT_RUNNING;
            end else if (phase[slot] == PH_ACTIVE) begin
              status_q <= ST_PENDING;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // slot phases
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_TIMERS; s++) begin
        phase[s] <= PH_IDLE;
      end
      rep <= '0;
    end else begin
      if (sweep_expire) begin
        phase[p_idx] <= PH_DONE;
      end
      if (cmd.exec && id_ok) begin
        case (mode_q)
          MODE_START: begin
            if (phase[slot] == PH_IDLE) begin
              phase[slot] <= PH_ACTIVE;
              rep[slot]   <= per_q;
            end
          end
          MODE_CANCEL: phase[slot] <= PH_IDLE;
          MODE_ACK: begin
            if (phase[slot] == PH_DONE) begin
              phase[slot] <= rep[slot] ? PH_ACTIVE : PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.status        <= status_q;
      out_data.expired_mask  <= expired[MASK_W-1:0];
      out_data.finished_mask <= done_vec[MASK_W-1:0];
    end
  end

endmodule

// ===== sv/multi_slot_software_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// Bank of NUM_TIMERS software timers, each with its own countdown.
// Input channel (in_valid/in_ready/in_data): one operation per transfer:
//   tick, start (one-shot or periodic), cancel, or acknowledge expiry.
// Output channel (out_valid/out_ready/out_data): one result per input:
//   status, slots expired on this tick, and slots now in the done phase.
// A start or cancel goes through the execute and finish states; an
// acknowledge first reads the reload length. A tick runs a sweep over
// the slots, one per cycle: each active slot's countdown is read,
// decremented and written back through the countdown memory's write port.
// One item is in the works at a time: the next is taken only once the
// last has left the finish state.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, the following item finishes its work
// and then holds until the output register is free.
// Reset (rst, synchronous) idles every slot and empties the output;
// in_ready stays low while rst is high.
// Count memories are not cleared; a slot's count is only read once written.
module multi_slot_software_timer_bank_unit
  import mstb_pkg::*;
#(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t  cmd;   // sequencing commands
  stat_t stat;  // sweep end, output register free

  mstb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (in_data.mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mstb_dpath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
